>>> rtl/i2cmts_pkg.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Item kinds, transfer phases, actions and bus state codes.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [2:0] phase_t;
  typedef logic [2:0] action_t;
  typedef logic [1:0] bus_t;

  localparam kind_t KIND_START_WR = 2'd0;
  localparam kind_t KIND_START_RD = 2'd1;
  localparam kind_t KIND_EVENT    = 2'd2;
  localparam kind_t KIND_UNUSED   = 2'd3;

  localparam phase_t PH_IDLE  = 3'd0;
  localparam phase_t PH_ERROR = 3'd1;
  localparam phase_t PH_WRITE = 3'd2;
  localparam phase_t PH_READ  = 3'd3;
  localparam phase_t PH_DONE  = 3'd4;

  localparam action_t ACT_ADDR     = 3'd0;
  localparam action_t ACT_SEND     = 3'd1;
  localparam action_t ACT_WDONE    = 3'd2;
  localparam action_t ACT_ACKREAD  = 3'd3;
  localparam action_t ACT_NACKSTOP = 3'd4;
  localparam action_t ACT_ERRSTOP  = 3'd5;
  localparam action_t ACT_FAULT    = 3'd6;
  localparam action_t ACT_IGNORED  = 3'd7;

  localparam bus_t BUS_OWNER = 2'd2;

endpackage

>>> rtl/i2c_master_transfer_sequencer.sv
// Each item passes through the input register, then its result is registered.
// Throughput: one item per cycle without back-pressure; the input and result
// registers each advance whenever the stage after them is free or drains.
// Transfer state (phase, remaining count, fault) updates as an item moves
// from the input register into the result register.
// Reset (rst_n low, synchronous) empties both stages, sets the phase to idle,
// clears the remaining count and the sticky fault.
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Decides one action per start, interrupt event or unused item; tracks the byte
// count, transfer phase and sticky fault of one master channel.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  i2cmts_pkg::kind_t      in_kind,
  input  logic [6:0]             in_target_address,
  input  logic [15:0]            in_byte_count,
  input  logic                   in_flag_master_on_bus,
  input  logic                   in_flag_slave_on_bus,
  input  logic                   in_arbitration_lost,
  input  logic                   in_no_ack_received,
  input  logic                   in_other_status_error,
  input  i2cmts_pkg::bus_t       in_bus_state,
  input  logic [7:0]             in_tx_byte,
  input  logic [7:0]             in_rx_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output i2cmts_pkg::action_t    out_action,
  output logic [7:0]             out_address_byte,
  output logic [7:0]             out_data_byte,
  output logic                   out_take_next_tx,
  output i2cmts_pkg::phase_t     out_transfer_state,
  output logic [15:0]            out_bytes_left,
  output logic                   out_fault
);
  import i2cmts_pkg::*;

  logic                   s1_valid_r;
  kind_t                  kind_r;
  logic [6:0]             addr_r;
  logic [15:0]            cnt_r;
  logic                   mb_r;
  logic                   sb_r;
  logic                   arb_r;
  logic                   nack_r;
  logic                   other_r;
  bus_t                   bus_r;
  logic [7:0]             txb_r;
  logic [7:0]             rxb_r;

  phase_t                 phase_r;
  phase_t                 phase_nxt;
  logic [COUNT_WIDTH-1:0] remaining_r;
  logic [COUNT_WIDTH-1:0] remaining_nxt;
  logic [COUNT_WIDTH-1:0] remaining_dec;
  logic                   fault_r;
  logic                   fault_nxt;

  action_t                action_nxt;
  logic [7:0]             abyte_nxt;
  logic [7:0]             dbyte_nxt;
  logic                   take_nxt;

  logic                   out_valid_r;
  action_t                action_r;
  logic [7:0]             abyte_r;
  logic [7:0]             dbyte_r;
  logic                   take_r;
  logic [15:0]            left_r;

  logic                   s1_adv;

  assign s1_adv        = !out_valid_r || out_ready;
  assign in_ready      = !s1_valid_r || s1_adv;
  assign remaining_dec = remaining_r - COUNT_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r  <= in_kind;
      addr_r  <= in_target_address;
      cnt_r   <= in_byte_count;
      mb_r    <= in_flag_master_on_bus;
      sb_r    <= in_flag_slave_on_bus;
      arb_r   <= in_arbitration_lost;
      nack_r  <= in_no_ack_received;
      other_r <= in_other_status_error;
      bus_r   <= in_bus_state;
      txb_r   <= in_tx_byte;
      rxb_r   <= in_rx_byte;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    fault_nxt     = fault_r;
    action_nxt    = ACT_FAULT;
    abyte_nxt     = 8'd0;
    dbyte_nxt     = 8'd0;
    take_nxt      = 1'b0;
    priority if (fault_r) begin
      action_nxt = ACT_FAULT;
    end else if (kind_r == KIND_START_WR || kind_r == KIND_START_RD) begin
      phase_nxt     = (kind_r == KIND_START_RD) ? PH_READ : PH_WRITE;
      remaining_nxt = COUNT_WIDTH'(cnt_r);
      abyte_nxt     = {addr_r, kind_r[0]};
      action_nxt    = ACT_ADDR;
    end else if (kind_r == KIND_UNUSED) begin
      action_nxt = ACT_IGNORED;
    end else if (arb_r || nack_r) begin
      phase_nxt  = PH_ERROR;
      action_nxt = ACT_ERRSTOP;
    end else if (other_r || bus_r != BUS_OWNER) begin
      fault_nxt  = 1'b1;
      action_nxt = ACT_FAULT;
    end else if (mb_r && phase_r == PH_WRITE) begin
      if (remaining_r != '0) begin
        remaining_nxt = remaining_dec;
        dbyte_nxt     = txb_r;
        take_nxt      = 1'b1;
        action_nxt    = ACT_SEND;
      end else begin
        phase_nxt  = PH_DONE;
        action_nxt = ACT_WDONE;
      end
    end else if (sb_r && phase_r == PH_READ && remaining_r != '0) begin
      dbyte_nxt     = rxb_r;
      remaining_nxt = remaining_dec;
      if (remaining_dec != '0) begin
        action_nxt = ACT_ACKREAD;
      end else begin
        phase_nxt  = PH_DONE;
        action_nxt = ACT_NACKSTOP;
      end
    end else begin
      fault_nxt  = 1'b1;
      action_nxt = ACT_FAULT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      remaining_r <= '0;
      fault_r     <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        phase_r     <= phase_nxt;
        remaining_r <= remaining_nxt;
        fault_r     <= fault_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      action_r <= action_nxt;
      abyte_r  <= abyte_nxt;
      dbyte_r  <= dbyte_nxt;
      take_r   <= take_nxt;
      left_r   <= 16'(remaining_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = action_r;
  assign out_address_byte   = abyte_r;
  assign out_data_byte      = dbyte_r;
  assign out_take_next_tx   = take_r;
  assign out_transfer_state = phase_r;
  assign out_bytes_left     = left_r;
  assign out_fault          = fault_r;

  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fault_r |=> fault_r)
    else $error("sticky fault cleared");

  a_take_only_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (take_r == (action_r == ACT_SEND)))
    else $error("take_next_tx disagrees with action");

  a_addr_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && action_r == ACT_ADDR) |->
      (phase_r == PH_WRITE || phase_r == PH_READ))
    else $error("address load without transfer phase");

  a_nack_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && action_r == ACT_NACKSTOP) |->
      (phase_r == PH_DONE && remaining_r == '0))
    else $error("read finished with bytes left");

  a_fault_action: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_valid_r && fault_r) |=> (action_r == ACT_FAULT))
    else $error("item after fault not answered as fault");

endmodule

>>> test/i2cmts_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer checker
// Watches both channels, works out the expected result of every accepted item
// from its own copy of phase, byte count and sticky fault, and compares each
// accepted result, field by field, with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module i2cmts_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  i2cmts_pkg::kind_t   in_kind,
  input  logic [6:0]          in_target_address,
  input  logic [15:0]         in_byte_count,
  input  logic                in_flag_master_on_bus,
  input  logic                in_flag_slave_on_bus,
  input  logic                in_arbitration_lost,
  input  logic                in_no_ack_received,
  input  logic                in_other_status_error,
  input  i2cmts_pkg::bus_t    in_bus_state,
  input  logic [7:0]          in_tx_byte,
  input  logic [7:0]          in_rx_byte,
  input  logic                out_valid,
  input  logic                out_ready,
  input  i2cmts_pkg::action_t out_action,
  input  logic [7:0]          out_address_byte,
  input  logic [7:0]          out_data_byte,
  input  logic                out_take_next_tx,
  input  i2cmts_pkg::phase_t  out_transfer_state,
  input  logic [15:0]         out_bytes_left,
  input  logic                out_fault,
  output int unsigned         n_mismatch,
  output int unsigned         n_pending
);
  import i2cmts_pkg::*;

  typedef struct packed {
    action_t     action;
    logic [7:0]  address_byte;
    logic [7:0]  data_byte;
    logic        take_next_tx;
    phase_t      transfer_state;
    logic [15:0] bytes_left;
    logic        fault;
  } decision_t;

  phase_t      cur_phase;
  logic [15:0] count_left;
  logic        fault_latched;
  decision_t   decisions_due[$];

  initial begin
    n_mismatch = 0;
    n_pending  = 0;
  end

  task automatic decide(input kind_t k, input logic [6:0] addr, input logic [15:0] cnt,
                        input logic mb, input logic sb, input logic arb, input logic nack,
                        input logic other, input bus_t bus, input logic [7:0] txb,
                        input logic [7:0] rxb, output decision_t d);
    d = '0;
    d.action = ACT_FAULT;
    if (fault_latched) begin
      d.action = ACT_FAULT;
    end else if (k == KIND_START_WR || k == KIND_START_RD) begin
      cur_phase      = (k == KIND_START_RD) ? PH_READ : PH_WRITE;
      count_left     = cnt;
      d.address_byte = {addr, k[0]};
      d.action       = ACT_ADDR;
    end else if (k == KIND_UNUSED) begin
      d.action = ACT_IGNORED;
    end else if (arb || nack) begin
      cur_phase = PH_ERROR;
      d.action  = ACT_ERRSTOP;
    end else if (other || bus != BUS_OWNER) begin
      fault_latched = 1'b1;
    end else if (mb && cur_phase == PH_WRITE) begin
      if (count_left != 0) begin
        count_left     = count_left - 1'b1;
        d.data_byte    = txb;
        d.take_next_tx = 1'b1;
        d.action       = ACT_SEND;
      end else begin
        cur_phase = PH_DONE;
        d.action  = ACT_WDONE;
      end
    end else if (sb && cur_phase == PH_READ && count_left != 0) begin
      d.data_byte = rxb;
      count_left  = count_left - 1'b1;
      if (count_left != 0) begin
        d.action = ACT_ACKREAD;
      end else begin
        cur_phase = PH_DONE;
        d.action  = ACT_NACKSTOP;
      end
    end else begin
      fault_latched = 1'b1;
    end
    d.transfer_state = cur_phase;
    d.bytes_left     = count_left;
    d.fault          = fault_latched;
  endtask

  always @(posedge clk) begin
    decision_t d;
    decision_t got;
    if (!rst_n) begin
      cur_phase     = PH_IDLE;
      count_left    = '0;
      fault_latched = 1'b0;
      decisions_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        decide(in_kind, in_target_address, in_byte_count, in_flag_master_on_bus,
               in_flag_slave_on_bus, in_arbitration_lost, in_no_ack_received,
               in_other_status_error, in_bus_state, in_tx_byte, in_rx_byte, d);
        decisions_due.push_back(d);
      end
      if (out_valid && out_ready) begin
        got = '{out_action, out_address_byte, out_data_byte, out_take_next_tx,
                out_transfer_state, out_bytes_left, out_fault};
        if (decisions_due.size() == 0) begin
          if (n_mismatch < 10)
            $display("%0t: result with no item outstanding: action=%0d addr=%02h data=%02h",
                     $realtime, got.action, got.address_byte, got.data_byte);
          n_mismatch <= n_mismatch + 1;
        end else begin
          d = decisions_due.pop_front();
          if (got !== d) begin
            if (n_mismatch < 10) begin
              $display("%0t: mismatch, expected action=%0d addr=%02h data=%02h take=%0d state=%0d left=%0d fault=%0d",
                       $realtime, d.action, d.address_byte, d.data_byte, d.take_next_tx,
                       d.transfer_state, d.bytes_left, d.fault);
              $display("%0t:           actual   action=%0d addr=%02h data=%02h take=%0d state=%0d left=%0d fault=%0d",
                       $realtime, got.action, got.address_byte, got.data_byte, got.take_next_tx,
                       got.transfer_state, got.bytes_left, got.fault);
            end
            n_mismatch <= n_mismatch + 1;
          end
        end
      end
    end
    n_pending <= decisions_due.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer testbench
// Drives directed and then randomised write and read transfers, error events
// and ignored items into the sequencer under random idling on both channels,
// ends with a sticky fault, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cmts_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [6:0]  addr;
    logic [15:0] count;
    logic        mb;
    logic        sb;
    logic        arb;
    logic        nack;
    logic        other;
    bus_t        bus;
    logic [7:0]  txb;
    logic [7:0]  rxb;
  } req_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  kind_t       in_kind;
  logic [6:0]  in_target_address;
  logic [15:0] in_byte_count;
  logic        in_flag_master_on_bus;
  logic        in_flag_slave_on_bus;
  logic        in_arbitration_lost;
  logic        in_no_ack_received;
  logic        in_other_status_error;
  bus_t        in_bus_state;
  logic [7:0]  in_tx_byte;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  action_t     out_action;
  logic [7:0]  out_address_byte;
  logic [7:0]  out_data_byte;
  logic        out_take_next_tx;
  phase_t      out_transfer_state;
  logic [15:0] out_bytes_left;
  logic        out_fault;
  int unsigned n_mismatch;
  int unsigned n_pending;

  int unsigned tx_idle_pct = 18;
  int unsigned rx_idle_pct = 67;
  int unsigned stall_seq   = 0;
  int unsigned stall_seen  = 0;
  int unsigned stall_left  = 0;
  int unsigned n_items     = 0;

  i2c_master_transfer_sequencer i_dut (.*);
  i2cmts_checker i_chk (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (stall_seq != stall_seen) begin
      stall_seen <= stall_seq;
      stall_left <= 150;
      out_ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic req_t rand_req();
    req_t r;
    r.kind  = kind_t'($urandom);
    r.addr  = 7'($urandom);
    r.count = 16'($urandom);
    r.mb    = 1'($urandom);
    r.sb    = 1'($urandom);
    r.arb   = 1'($urandom);
    r.nack  = 1'($urandom);
    r.other = 1'($urandom);
    r.bus   = bus_t'($urandom);
    r.txb   = 8'($urandom);
    r.rxb   = 8'($urandom);
    return r;
  endfunction

  function automatic req_t start_req(kind_t k, logic [6:0] a, logic [15:0] n);
    req_t r;
    r       = rand_req();
    r.kind  = k;
    r.addr  = a;
    r.count = n;
    return r;
  endfunction

  function automatic req_t event_req(logic mb, logic sb);
    req_t r;
    r       = rand_req();
    r.kind  = KIND_EVENT;
    r.mb    = mb;
    r.sb    = sb;
    r.arb   = 1'b0;
    r.nack  = 1'b0;
    r.other = 1'b0;
    r.bus   = BUS_OWNER;
    return r;
  endfunction

  function automatic req_t error_req();
    req_t r;
    r             = rand_req();
    r.kind        = KIND_EVENT;
    {r.arb, r.nack} = 2'($urandom_range(1, 3));
    return r;
  endfunction

  function automatic req_t noise_req();
    req_t r;
    r      = rand_req();
    r.kind = KIND_UNUSED;
    return r;
  endfunction

  task automatic push(input req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_kind               <= r.kind;
    in_target_address     <= r.addr;
    in_byte_count         <= r.count;
    in_flag_master_on_bus <= r.mb;
    in_flag_slave_on_bus  <= r.sb;
    in_arbitration_lost   <= r.arb;
    in_no_ack_received    <= r.nack;
    in_other_status_error <= r.other;
    in_bus_state          <= r.bus;
    in_tx_byte            <= r.txb;
    in_rx_byte            <= r.rxb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (r.kind != KIND_UNUSED) n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  // one start with random content, drained in full or cut short
  task automatic run_transfer();
    logic rd;
    logic broken;
    int   n;
    int   cut;
    int   err_at;
    int   i;
    rd = 1'($urandom);
    n  = ($urandom_range(9) == 0) ? int'($urandom_range(16'hffff)) : int'($urandom_range(6));
    push(start_req(rd ? KIND_START_RD : KIND_START_WR, 7'($urandom), 16'(n)));
    broken = (n > 6) || ($urandom_range(9) == 0);
    cut    = broken ? int'($urandom_range((n < 4) ? n : 4)) : n;
    err_at = ($urandom_range(9) == 0) ? int'($urandom_range(cut)) : -1;
    for (i = 0; i <= cut; i++) begin
      if ($urandom_range(9) == 0) push(noise_req());
      if (i == err_at) begin
        push(error_req());
        if ($urandom_range(1) == 1) push(error_req());
        return;
      end
      if (i < cut)
        push(rd ? event_req(1'($urandom), 1'b1) : event_req(1'b1, 1'($urandom)));
      else if (!rd && !broken)
        push(event_req(1'b1, 1'($urandom)));
    end
  endtask

  initial begin
    req_t r;
    rst_n                 <= 1'b0;
    in_valid              <= 1'b0;
    in_kind               <= KIND_UNUSED;
    in_target_address     <= '0;
    in_byte_count         <= '0;
    in_flag_master_on_bus <= 1'b0;
    in_flag_slave_on_bus  <= 1'b0;
    in_arbitration_lost   <= 1'b0;
    in_no_ack_received    <= 1'b0;
    in_other_status_error <= 1'b0;
    in_bus_state          <= '0;
    in_tx_byte            <= '0;
    in_rx_byte            <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push(start_req(KIND_START_WR, 7'h7f, 16'd0));
    push(event_req(1'b1, 1'b0));
    push(start_req(KIND_START_RD, 7'h00, 16'd1));
    r = event_req(1'b1, 1'b1);
    r.rxb = 8'hff;
    push(r);
    push(start_req(KIND_START_WR, 7'h55, 16'd2));
    r = event_req(1'b1, 1'b0);
    r.txb = 8'hff;
    push(r);
    r = event_req(1'b1, 1'b1);
    r.txb = 8'h00;
    push(r);
    push(event_req(1'b1, 1'b0));
    push(start_req(KIND_START_RD, 7'h2a, 16'd3));
    r = event_req(1'b0, 1'b1);
    r.rxb = 8'h00;
    push(r);
    r = rand_req();
    r.kind = KIND_EVENT;
    {r.mb, r.sb, r.arb, r.nack, r.other, r.bus} = {1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 2'd0};
    push(r);
    push(start_req(KIND_START_WR, 7'h01, 16'hffff));
    r = error_req();
    {r.arb, r.nack, r.other, r.bus} = {1'b0, 1'b1, 1'b0, 2'd3};
    push(r);
    r = error_req();
    {r.arb, r.nack, r.other, r.bus} = {1'b1, 1'b0, 1'b1, 2'd1};
    push(r);
    r = noise_req();
    {r.addr, r.count, r.mb, r.sb, r.arb, r.nack, r.other, r.bus, r.txb, r.rxb} = '1;
    push(r);
    r = noise_req();
    {r.addr, r.count, r.mb, r.sb, r.arb, r.nack, r.other, r.bus, r.txb, r.rxb} = '0;
    push(r);
    push(start_req(KIND_START_RD, 7'h7f, 16'hffff));
    push(event_req(1'b1, 1'b1));
    push(start_req(KIND_START_WR, 7'h40, 16'h8001));
    push(start_req(KIND_START_WR, 7'h3f, 16'd1));
    push(event_req(1'b1, 1'b1));
    push(event_req(1'b1, 1'b0));

    while (n_items < 350) run_transfer();
    drain();

    tx_idle_pct <= 67;
    rx_idle_pct <= 18;
    while (n_items < 700) run_transfer();
    drain();

    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    stall_seq   <= stall_seq + 1;
    while (n_items < 1000) run_transfer();
    drain();

    // latch the sticky fault, then show it holds for every kind of item
    case ($urandom_range(3))
      0: begin
        r = event_req(1'($urandom), 1'($urandom));
        r.other = 1'b1;
        push(r);
      end
      1: begin
        r = event_req(1'($urandom), 1'($urandom));
        r.bus = bus_t'($urandom_range(2)) ^ 2'd0;
        if (r.bus == BUS_OWNER) r.bus = 2'd3;
        push(r);
      end
      2: begin
        push(start_req(KIND_START_RD, 7'($urandom), 16'd0));
        push(event_req(1'($urandom), 1'b1));
      end
      default: begin
        push(start_req(KIND_START_RD, 7'($urandom), 16'd5));
        push(event_req(1'b1, 1'b0));
      end
    endcase
    push(start_req(KIND_START_WR, 7'($urandom), 16'd3));
    push(event_req(1'b1, 1'b0));
    push(start_req(KIND_START_RD, 7'($urandom), 16'd3));
    push(event_req(1'b0, 1'b1));
    push(noise_req());
    push(error_req());
    drain();
    repeat (8) @(posedge clk);

    if (n_mismatch == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
